FILE: rtl/aes_dec_pkg.sv
// Package for the AES-128 decrypt core: types, S-box table, GF helpers.
// Used by every module under rtl; no other dependencies.
package aes_dec_pkg;
  localparam int unsigned RoundsDef = 10;
  localparam int unsigned SlotW = 4;
  localparam int unsigned HalfW = 64;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_e;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2;
    logic [7:0] a4;
    logic [7:0] a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    gmul = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
         ^ (b[3] ? a8 : 8'h00);
  endfunction

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
      t[119 - 32 * c -: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
      t[111 - 32 * c -: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
      t[103 - 32 * c -: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
    end
    inv_mix = t;
  endfunction
endpackage

FILE: rtl/aes128_block_decrypt_core.sv
// AES-128 inverse cipher, one round per pipeline stage (ROUNDS+1 stages deep).
// A decrypt word passes stage 0, then each round stage; throughput one word per cycle while stall_o is low.
// A load word writes a round key register and yields no output word; it waits
// while any decrypt word is still in stage 0 or in a round stage before the last.
// Reset clears valid bits only; round keys are undefined until loaded.
// Depends on aes_dec_pkg and aes_dec_round.
module aes128_block_decrypt_core #(
  parameter int unsigned ROUNDS = aes_dec_pkg::RoundsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic                              kind_i,
  input  logic [aes_dec_pkg::SlotW-1:0]     key_slot_i,
  input  logic [aes_dec_pkg::HalfW-1:0]     value_high_i,
  input  logic [aes_dec_pkg::HalfW-1:0]     value_low_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [aes_dec_pkg::HalfW-1:0]     plain_high_o,
  output logic [aes_dec_pkg::HalfW-1:0]     plain_low_o
);
  import aes_dec_pkg::*;

  logic   adv;
  logic   acc;
  logic   dec_acc;
  logic   load_hold;
  block_t in_blk;
  block_t key0_q;
  block_t s0_d, s0_q;
  logic   v0_q;
  logic   [ROUNDS:0] vld;
  block_t stg [ROUNDS+1];

  assign adv       = !(valid_o && stall_i);
  assign load_hold = valid_i && (kind_i == KIND_LOAD) && (|vld[ROUNDS-1:0]);
  assign stall_o   = !adv || load_hold;
  assign acc       = valid_i && !stall_o;
  assign dec_acc   = acc && (kind_i == KIND_DECRYPT);
  assign in_blk    = {value_high_i, value_low_i};

  always_ff @(posedge clk_i) begin
    if (acc && kind_i == KIND_LOAD && key_slot_i == SlotW'(ROUNDS)) begin
      key0_q <= in_blk;
    end
    if (adv) begin
      s0_q <= s0_d;
    end
  end

  assign s0_d = in_blk ^ key0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= dec_acc;
    end
  end

  assign vld[0] = v0_q;
  assign stg[0] = s0_q;

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_rnd
    aes_dec_round u_rnd (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .key_we_i (acc && kind_i == KIND_LOAD && key_slot_i == SlotW'(ROUNDS - g)),
      .key_i    (in_blk),
      .mix_i    (g != ROUNDS),
      .valid_i  (vld[g-1]),
      .state_i  (stg[g-1]),
      .valid_o  (vld[g]),
      .state_o  (stg[g])
    );
  end

  assign valid_o      = vld[ROUNDS];
  assign plain_high_o = stg[ROUNDS][127:64];
  assign plain_low_o  = stg[ROUNDS][63:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(plain_high_o) && $stable(plain_low_o))
    else $error("output word changed under stall");
  a_nodec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && kind_i == KIND_LOAD |=> !v0_q)
    else $error("load word entered pipeline");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o || (valid_i && kind_i == KIND_LOAD))
    else $error("stall without output word or waiting load word");
endmodule

FILE: rtl/aes_dec_round.sv
// One pipelined inverse round stage with its own round key register.
// Depends on aes_dec_pkg.
module aes_dec_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 key_we_i,
  input  aes_dec_pkg::block_t  key_i,
  input  logic                 mix_i,
  input  logic                 valid_i,
  input  aes_dec_pkg::block_t  state_i,
  output logic                 valid_o,
  output aes_dec_pkg::block_t  state_o
);
  import aes_dec_pkg::*;

  block_t key_q;
  block_t state_d, state_q;
  logic   valid_q;

  always_comb begin
    state_d = inv_shift_sub(state_i) ^ key_q;
    if (mix_i) begin
      state_d = inv_mix(state_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_q <= key_i;
    end
    if (adv_i) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule
